/* rtl/sdf_pkg.sv */
// Shared types and constants for the sample packet deframer.
package sdf_pkg;

  localparam int HdrBytes = 28;
  localparam int HdrBits  = HdrBytes * 8;
  localparam int HdrPosW  = 5;

  typedef enum logic [2:0] {
    CodeHeader     = 3'd0,
    CodeSample     = 3'd1,
    CodeShort      = 3'd2,
    CodeOverrun    = 3'd3,
    CodeHdrOverrun = 3'd4,
    CodeSmpOverrun = 3'd5
  } result_code_e;

  typedef struct packed {
    result_code_e       result_code;
    logic [7:0]         frame_type;
    logic [7:0]         unit_number;
    logic [15:0]        reserved_bytes;
    logic [31:0]        sequence_number;
    logic [15:0]        channel_count;
    logic [15:0]        bundle_count;
    logic [63:0]        first_sample_index;
    logic [63:0]        first_sample_time;
    logic signed [23:0] sample_value;
    logic [15:0]        channel_index;
    logic [15:0]        bundle_index;
  } result_t;

endpackage

/* rtl/sdf_core.sv */
// Deframer state and per-byte decode logic.
module sdf_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  output logic            res_valid_o,
  output sdf_pkg::result_t res_o
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhSamples = 3'b010,
    PhTrail   = 3'b100
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [HdrPosW-1:0]   pos_q, pos_d;
  logic [HdrBits-1:0]   hdr_q, hdr_d;
  logic [15:0]          partial_q, partial_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [15:0]          chan_q, chan_d;
  logic [15:0]          bund_q, bund_d;

  logic        need;
  logic [15:0] chan_inc, bund_inc;
  logic        done;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    partial_d   = partial_q;
    cnt_d       = cnt_q;
    chan_d      = chan_q;
    bund_d      = bund_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    need        = 1'b0;
    done        = 1'b0;
    chan_inc    = chan_q + 16'd1;
    bund_inc    = bund_q + 16'd1;

    unique case (phase_q)
      PhHeader: begin
        // Header shifts in big-endian; byte 0 ends up at the top.
        hdr_d = {hdr_q[HdrBits-9:0], data_byte_i};
        if (pos_q == HdrPosW'(HdrBytes - 1)) begin
          need                     = (hdr_d[159:144] != 16'd0) && (hdr_d[143:128] != 16'd0);
          res_valid_o              = 1'b1;
          res_o.frame_type         = hdr_d[223:216];
          res_o.unit_number        = hdr_d[215:208];
          res_o.reserved_bytes     = hdr_d[207:192];
          res_o.sequence_number    = hdr_d[191:160];
          res_o.channel_count      = hdr_d[159:144];
          res_o.bundle_count       = hdr_d[143:128];
          res_o.first_sample_index = hdr_d[127:64];
          res_o.first_sample_time  = hdr_d[63:0];
          pos_d                    = '0;
          partial_d                = '0;
          cnt_d                    = '0;
          chan_d                   = '0;
          bund_d                   = '0;
          if (last_byte_i) begin
            res_o.result_code = need ? CodeHdrOverrun : CodeHeader;
            phase_d           = PhHeader;
          end else begin
            res_o.result_code = CodeHeader;
            phase_d           = need ? PhSamples : PhTrail;
          end
        end else begin
          pos_d = pos_q + HdrPosW'(1);
          if (last_byte_i) begin
            res_valid_o       = 1'b1;
            res_o.result_code = CodeShort;
            pos_d             = '0;
          end
        end
      end
      PhSamples: begin
        if (cnt_q != 2'd2) begin
          partial_d = {partial_q[7:0], data_byte_i};
          cnt_d     = cnt_q + 2'd1;
          if (last_byte_i) begin
            // packet ended inside a sample
            res_valid_o         = 1'b1;
            res_o.result_code   = CodeOverrun;
            res_o.channel_index = chan_q;
            res_o.bundle_index  = bund_q;
            phase_d             = PhHeader;
            pos_d               = '0;
            partial_d           = '0;
            cnt_d               = '0;
            chan_d              = '0;
            bund_d              = '0;
          end
        end else begin
          res_valid_o         = 1'b1;
          res_o.sample_value  = {partial_q, data_byte_i};
          res_o.channel_index = chan_q;
          res_o.bundle_index  = bund_q;
          partial_d           = '0;
          cnt_d               = '0;
          if (chan_inc >= hdr_q[159:144]) begin
            chan_d = '0;
            bund_d = bund_inc;
          end else begin
            chan_d = chan_inc;
          end
          done = bund_d >= hdr_q[143:128];
          if (last_byte_i) begin
            res_o.result_code = done ? CodeSample : CodeSmpOverrun;
            phase_d           = PhHeader;
            pos_d             = '0;
            chan_d            = '0;
            bund_d            = '0;
          end else begin
            res_o.result_code = CodeSample;
            phase_d           = done ? PhTrail : PhSamples;
          end
        end
      end
      PhTrail: begin
        if (last_byte_i) begin
          phase_d   = PhHeader;
          pos_d     = '0;
          partial_d = '0;
          cnt_d     = '0;
          chan_d    = '0;
          bund_d    = '0;
        end
      end
      default: begin
        phase_d = PhHeader;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      pos_q     <= '0;
      partial_q <= '0;
      cnt_q     <= '0;
      chan_q    <= '0;
      bund_q    <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      partial_q <= partial_d;
      cnt_q     <= cnt_d;
      chan_q    <= chan_d;
      bund_q    <= bund_d;
    end
  end

  // header bytes are fully rewritten before any read, so no reset
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hdr_q <= hdr_d;
    end
  end

endmodule

/* rtl/sdf_out_reg.sv */
// Result register with valid/stall handshake toward the consumer.
module sdf_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sdf_pkg::result_t data_i,
  input  logic             stall_i,
  output logic             free_o,
  output logic             valid_o,
  output sdf_pkg::result_t data_o
);
  import sdf_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

endmodule

/* rtl/sample_packet_deframer_unit.sv */
// Top level of the sample packet deframer: input register, decode core, result register.
// One packet byte per request, last_byte_i marking the end of the packet. The 28-byte
// big-endian header is reported once as a header result; after it come signed 24-bit
// samples, one result per third byte, tagged with channel and bundle index (channel
// fastest). A packet that ends early reports a short-packet or overrun code; bytes past
// the last sample produce nothing. A byte is taken every clock unless in_stall_o holds it
// back: it is held in the input register, decoded against the packet state, and its result,
// if any, is loaded into the result register. Only a stalled, occupied result register
// holds the input back.
module sample_packet_deframer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         result_code_o,
  output logic [7:0]         frame_type_o,
  output logic [7:0]         unit_number_o,
  output logic [15:0]        reserved_bytes_o,
  output logic [31:0]        sequence_number_o,
  output logic [15:0]        channel_count_o,
  output logic [15:0]        bundle_count_o,
  output logic [63:0]        first_sample_index_o,
  output logic [63:0]        first_sample_time_o,
  output logic signed [23:0] sample_value_o,
  output logic [15:0]        channel_index_o,
  output logic [15:0]        bundle_index_o
);
  import sdf_pkg::*;

  logic       in_v_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       res_free;
  logic       fire;
  logic       res_valid;
  result_t    res, res_out;

  assign fire       = in_v_q && res_free;
  assign in_stall_o = in_v_q && !res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  sdf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdf_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res_valid),
    .data_i  (res),
    .stall_i (out_stall_i),
    .free_o  (res_free),
    .valid_o (out_valid_o),
    .data_o  (res_out)
  );

  assign result_code_o        = res_out.result_code;
  assign frame_type_o         = res_out.frame_type;
  assign unit_number_o        = res_out.unit_number;
  assign reserved_bytes_o     = res_out.reserved_bytes;
  assign sequence_number_o    = res_out.sequence_number;
  assign channel_count_o      = res_out.channel_count;
  assign bundle_count_o       = res_out.bundle_count;
  assign first_sample_index_o = res_out.first_sample_index;
  assign first_sample_time_o  = res_out.first_sample_time;
  assign sample_value_o       = res_out.sample_value;
  assign channel_index_o      = res_out.channel_index;
  assign bundle_index_o       = res_out.bundle_index;

endmodule
